FILE: hdl/slmi_pkg.sv
// ----------------------------------------------------------------------------
// slmi_pkg
// Shared types, codes and constants of the servo linear move interpolator.
// ----------------------------------------------------------------------------
package slmi_pkg;

  // Field widths
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned PULSE_W = 12;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned WAIT_W  = 11;
  localparam int unsigned CMD_W   = 2;

  // Defaults of the top-level parameters
  localparam int unsigned DEF_CHANNELS = 12;
  localparam int unsigned DEF_STEPS    = 60;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 8'd180;
  localparam logic [WAIT_W-1:0]  WAIT_MAX      = 11'd2047;
  localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd150;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd600;

  // Division by 180 as a reciprocal multiply: exact for dividends below 2**20
  localparam int unsigned     P2_W       = ANGLE_W + PULSE_W;
  localparam int unsigned     PDIV_SHIFT = 28;
  localparam int unsigned     PDIV_MUL_W = 21;
  localparam logic [20:0]     PDIV_MUL   = 21'd1491309;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_TARGET   = 2'd0,
    CMD_SET_POSITION = 2'd1,
    CMD_START        = 2'd2,
    CMD_TICK         = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic CFG_PULSE_MIN = 1'b0;
  localparam logic CFG_PULSE_MAX = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_goal;
    logic wr_cur;
    logic latch_start;
    logic commit_goal;
    logic load_wait;
    logic iss_valid;
    logic iss_last;
    logic iss_done;
    logic iss_pos;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic              pipe_busy;
    logic [WAIT_W-1:0] step_wait;
  } dp_stat_t;

  // Tag carried along the result pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic done;
  } tag_t;

  function automatic int unsigned ch_width(int unsigned n);
    return (n > 16) ? $clog2(n) : 4;
  endfunction

  function automatic int unsigned idx_width(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

FILE: hdl/servo_linear_move_interpolator.sv
// ----------------------------------------------------------------------------
// servo_linear_move_interpolator
// Moves servo angles linearly to loaded targets in STEPS steps paced by
// millisecond ticks, and emits angle and PWM pulse for every channel.
// ----------------------------------------------------------------------------
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+---------------
//  command  | cmd_i channel_i target_angle_i duration_ms_i   | start_i, busy_o
//  result   | out_channel_o out_angle_o pulse_o last_o       | valid_o
//           | done_res_o                                     |
//  config   | cfg_idx_i cfg_data_i                           | cfg_we_i
//
//  A command is taken when start_i is high and busy_o is low. A step (start,
//  or a tick whose wait runs out) keeps busy_o high while the issue
//  sequencer feeds the six-stage angle/pulse pipeline one channel per cycle
//  and until the pipeline has drained, as do set_position and the done
//  result. Each result is shown for one cycle on valid_o and cannot be
//  stalled. After reset the block is idle and ready at once.
// ----------------------------------------------------------------------------
module servo_linear_move_interpolator import slmi_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS,
  parameter int unsigned STEPS    = DEF_STEPS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [CMD_W-1:0]                 cmd_i,
  input  logic [ch_width(CHANNELS)-1:0]    channel_i,
  input  logic [ANGLE_W-1:0]               target_angle_i,
  input  logic [DUR_W-1:0]                 duration_ms_i,
  output logic                             valid_o,
  output logic [ch_width(CHANNELS)-1:0]    out_channel_o,
  output logic [ANGLE_W-1:0]               out_angle_o,
  output logic [PULSE_W-1:0]               pulse_o,
  output logic                             last_o,
  output logic                             done_res_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [PULSE_W-1:0]               cfg_data_i
);

  dp_cmd_t                          dp_cmd;
  dp_stat_t                         stat;
  logic [idx_width(CHANNELS)-1:0]   iss_ch;
  logic [$clog2(STEPS+1)-1:0]       step;

  slmi_ctrl #(
    .CHANNELS (CHANNELS),
    .STEPS    (STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .cmd_i     (cmd_i),
    .channel_i (channel_i),
    .busy_o    (busy_o),
    .dp_cmd_o  (dp_cmd),
    .iss_ch_o  (iss_ch),
    .step_o    (step),
    .stat_i    (stat)
  );

  slmi_datapath #(
    .CHANNELS (CHANNELS),
    .STEPS    (STEPS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .iss_ch_i       (iss_ch),
    .step_i         (step),
    .channel_i      (channel_i),
    .target_angle_i (target_angle_i),
    .duration_ms_i  (duration_ms_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .stat_o         (stat),
    .valid_o        (valid_o),
    .out_channel_o  (out_channel_o),
    .out_angle_o    (out_angle_o),
    .pulse_o        (pulse_o),
    .last_o         (last_o),
    .done_res_o     (done_res_o)
  );

  // results only leave while the request that caused them is still held busy
  a_valid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result emitted while idle");

  a_issue_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.iss_valid |-> busy_o)
    else $error("pipeline issue while idle");

  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && done_res_o) |-> (last_o && pulse_o == '0 && out_angle_o == '0))
    else $error("malformed done result");

  a_wait_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.step_wait != '0)
    else $error("step wait is zero");

endmodule

FILE: hdl/slmi_ctrl.sv
// ----------------------------------------------------------------------------
// slmi_ctrl
// Command decode, move timing (step and wait counters) and issue sequencer.
// ----------------------------------------------------------------------------
module slmi_ctrl import slmi_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS,
  parameter int unsigned STEPS    = DEF_STEPS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [CMD_W-1:0]                    cmd_i,
  input  logic [ch_width(CHANNELS)-1:0]       channel_i,
  output logic                                busy_o,
  output dp_cmd_t                             dp_cmd_o,
  output logic [idx_width(CHANNELS)-1:0]      iss_ch_o,
  output logic [$clog2(STEPS+1)-1:0]          step_o,
  input  dp_stat_t                            stat_i
);

  localparam int unsigned CHW  = ch_width(CHANNELS);
  localparam int unsigned IDXW = idx_width(CHANNELS);
  localparam int unsigned SW   = $clog2(STEPS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  logic              moving_q;
  logic [SW-1:0]     step_q;
  logic [WAIT_W-1:0] wait_q;
  logic              iss_valid_q;
  logic              iss_last_q;
  logic              iss_done_q;
  logic              iss_pos_q;
  logic [IDXW-1:0]   iss_ch_q;

  logic              accept;
  cmd_e              cmd;
  logic              ch_ok;
  logic [WAIT_W-1:0] wait_dec;
  logic              step_more;
  logic              tick_fire;

  always_comb begin
    accept    = start_i && (state_q == ST_IDLE);
    cmd       = cmd_e'(cmd_i);
    ch_ok     = {1'b0, channel_i} < (CHW+1)'(CHANNELS);
    wait_dec  = (wait_q != '0) ? wait_q - WAIT_W'(1) : '0;
    step_more = step_q < SW'(STEPS);
    tick_fire = accept && (cmd == CMD_TICK) && moving_q && (wait_dec == '0);

    dp_cmd_o.wr_goal     = accept && (cmd == CMD_SET_TARGET) && !moving_q && ch_ok;
    dp_cmd_o.wr_cur      = accept && (cmd == CMD_SET_POSITION) && !moving_q && ch_ok;
    dp_cmd_o.latch_start = accept && (cmd == CMD_START) && !moving_q;
    dp_cmd_o.load_wait   = accept && (cmd == CMD_START) && !moving_q;
    dp_cmd_o.commit_goal = tick_fire && !step_more;
    dp_cmd_o.iss_valid   = iss_valid_q;
    dp_cmd_o.iss_last    = iss_last_q;
    dp_cmd_o.iss_done    = iss_done_q;
    dp_cmd_o.iss_pos     = iss_pos_q;
  end

  assign iss_ch_o = iss_ch_q;
  assign step_o   = step_q;
  assign busy_o   = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      moving_q    <= 1'b0;
      step_q      <= '0;
      wait_q      <= '0;
      iss_valid_q <= 1'b0;
      iss_last_q  <= 1'b0;
      iss_done_q  <= 1'b0;
      iss_pos_q   <= 1'b0;
      iss_ch_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_SET_TARGET: begin
              end
              CMD_SET_POSITION: begin
                if (!moving_q && ch_ok) begin
                  iss_valid_q <= 1'b1;
                  iss_ch_q    <= channel_i[IDXW-1:0];
                  iss_last_q  <= 1'b1;
                  iss_done_q  <= 1'b0;
                  iss_pos_q   <= 1'b1;
                  state_q     <= ST_ISSUE;
                end
              end
              CMD_START: begin
                if (!moving_q) begin
                  moving_q    <= 1'b1;
                  step_q      <= SW'(1);
                  iss_valid_q <= 1'b1;
                  iss_ch_q    <= '0;
                  iss_last_q  <= (CHANNELS == 1);
                  iss_done_q  <= 1'b0;
                  iss_pos_q   <= 1'b0;
                  state_q     <= ST_ISSUE;
                end
              end
              CMD_TICK: begin
                if (moving_q) begin
                  wait_q <= wait_dec;
                  if (wait_dec == '0) begin
                    iss_valid_q <= 1'b1;
                    iss_ch_q    <= '0;
                    iss_pos_q   <= 1'b0;
                    state_q     <= ST_ISSUE;
                    if (step_more) begin
                      step_q     <= step_q + SW'(1);
                      iss_last_q <= (CHANNELS == 1);
                      iss_done_q <= 1'b0;
                    end else begin
                      // move complete: one done request
                      moving_q   <= 1'b0;
                      iss_last_q <= 1'b1;
                      iss_done_q <= 1'b1;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_ISSUE: begin
          if (iss_last_q) begin
            iss_valid_q <= 1'b0;
            state_q     <= ST_DRAIN;
          end else begin
            iss_ch_q   <= iss_ch_q + IDXW'(1);
            iss_last_q <= ((IDXW+1)'(iss_ch_q) + (IDXW+1)'(1)) == (IDXW+1)'(CHANNELS - 1);
          end
        end
        ST_DRAIN: begin
          // hold until the pipeline has emptied, then rearm the step wait if a move is running
          if (!stat_i.pipe_busy) begin
            state_q <= ST_IDLE;
            if (moving_q) begin
              wait_q <= stat_i.step_wait;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/slmi_datapath.sv
// ----------------------------------------------------------------------------
// slmi_datapath
// Angle stores, step wait divider and the six-stage angle/pulse pipeline.
// ----------------------------------------------------------------------------
module slmi_datapath import slmi_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS,
  parameter int unsigned STEPS    = DEF_STEPS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dp_cmd_t                          cmd_i,
  input  logic [idx_width(CHANNELS)-1:0]   iss_ch_i,
  input  logic [$clog2(STEPS+1)-1:0]       step_i,
  input  logic [ch_width(CHANNELS)-1:0]    channel_i,
  input  logic [ANGLE_W-1:0]               target_angle_i,
  input  logic [DUR_W-1:0]                 duration_ms_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [PULSE_W-1:0]               cfg_data_i,
  output dp_stat_t                         stat_o,
  output logic                             valid_o,
  output logic [ch_width(CHANNELS)-1:0]    out_channel_o,
  output logic [ANGLE_W-1:0]               out_angle_o,
  output logic [PULSE_W-1:0]               pulse_o,
  output logic                             last_o,
  output logic                             done_res_o
);

  localparam int unsigned CHW  = ch_width(CHANNELS);
  localparam int unsigned IDXW = idx_width(CHANNELS);
  localparam int unsigned SW   = $clog2(STEPS + 1);
  localparam int unsigned P1W  = ANGLE_W + SW;
  // reciprocal of STEPS, exact over the dividend range
  localparam int unsigned KS   = P1W + $clog2(STEPS);
  localparam logic [KS:0] MulS = (KS+1)'(((1 << KS) + STEPS - 1) / STEPS);
  localparam int unsigned KD   = DUR_W + $clog2(STEPS);
  localparam logic [KD:0] MulD = (KD+1)'(((1 << KD) + STEPS - 1) / STEPS);
  localparam int unsigned PSW  = P1W + KS + 1;
  localparam int unsigned PDW  = DUR_W + KD + 1;
  localparam int unsigned PPW  = P2_W + PDIV_MUL_W;

  // Configuration
  logic [PULSE_W-1:0] pulse_min_q;
  logic [PULSE_W-1:0] pulse_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_min_q <= PULSE_MIN_RST;
      pulse_max_q <= PULSE_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PULSE_MIN: pulse_min_q <= cfg_data_i;
        CFG_PULSE_MAX: pulse_max_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic               span_neg;
  logic [PULSE_W-1:0] span_mag;

  assign span_neg = pulse_max_q < pulse_min_q;
  assign span_mag = span_neg ? pulse_min_q - pulse_max_q : pulse_max_q - pulse_min_q;

  // Angle stores
  logic [ANGLE_W-1:0] cur_q   [CHANNELS];
  logic [ANGLE_W-1:0] goal_q  [CHANNELS];
  logic [ANGLE_W-1:0] start_q [CHANNELS];
  logic [ANGLE_W-1:0] ang_in;

  assign ang_in = (target_angle_i > ANGLE_MAX) ? ANGLE_MAX : target_angle_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cur_q[i]   <= '0;
        goal_q[i]  <= '0;
        start_q[i] <= '0;
      end
    end else begin
      if (cmd_i.wr_goal) begin
        goal_q[channel_i[IDXW-1:0]] <= ang_in;
      end
      if (cmd_i.wr_cur) begin
        cur_q[channel_i[IDXW-1:0]] <= ang_in;
      end
      if (cmd_i.commit_goal) begin
        for (int i = 0; i < CHANNELS; i++) begin
          cur_q[i] <= goal_q[i];
        end
      end
      if (cmd_i.latch_start) begin
        for (int i = 0; i < CHANNELS; i++) begin
          start_q[i] <= cur_q[i];
        end
      end
    end
  end

  // Step wait: duration / STEPS, clamped to 1 .. WAIT_MAX
  logic [PDW-1:0]    dprod_q;
  logic              ld_q;
  logic [WAIT_W-1:0] step_wait_q;
  logic [DUR_W-1:0]  dquot;

  assign dquot = dprod_q[KD +: DUR_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wait) begin
      dprod_q <= PDW'(duration_ms_i) * PDW'(MulD);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_q        <= 1'b0;
      step_wait_q <= WAIT_W'(1);
    end else begin
      ld_q <= cmd_i.load_wait;
      if (ld_q) begin
        if (dquot == '0) begin
          step_wait_q <= WAIT_W'(1);
        end else if (dquot > DUR_W'(WAIT_MAX)) begin
          step_wait_q <= WAIT_MAX;
        end else begin
          step_wait_q <= dquot[WAIT_W-1:0];
        end
      end
    end
  end

  // Result pipeline: tags and channel numbers of stages one to five
  tag_t            tag_q [5];
  logic [IDXW-1:0] ch_q  [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) begin
        tag_q[k] <= '0;
      end
    end else begin
      tag_q[0] <= '{valid: cmd_i.iss_valid, last: cmd_i.iss_last, done: cmd_i.iss_done};
      for (int k = 1; k < 5; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q[0] <= iss_ch_i;
    for (int k = 1; k < 5; k++) begin
      ch_q[k] <= ch_q[k-1];
    end
  end

  // Stage 1: |goal - start| * step; a set_position request passes its angle straight
  logic [ANGLE_W-1:0] s0;
  logic [ANGLE_W-1:0] g;
  logic               neg;
  logic [ANGLE_W-1:0] mag;
  logic [ANGLE_W-1:0] s0_q1;
  logic               neg_q1;
  logic [P1W-1:0]     p1_q;

  assign s0  = cmd_i.iss_pos ? cur_q[iss_ch_i] : start_q[iss_ch_i];
  assign g   = cmd_i.iss_pos ? cur_q[iss_ch_i] : goal_q[iss_ch_i];
  assign neg = g < s0;
  assign mag = neg ? s0 - g : g - s0;

  // Stage 2: divide by STEPS
  logic [PSW-1:0]     prod_s;
  logic [ANGLE_W-1:0] s0_q2;
  logic               neg_q2;
  logic [ANGLE_W-1:0] q1_q;

  assign prod_s = PSW'(p1_q) * PSW'(MulS);

  // Stages 3 to 5: angle, angle * span, divide by 180
  logic [ANGLE_W-1:0] ang_q3;
  logic [ANGLE_W-1:0] ang_q4;
  logic [P2_W-1:0]    p2_q4;
  logic [ANGLE_W-1:0] ang_q5;
  logic [PPW-1:0]     prod_p;
  logic [PULSE_W-1:0] q2_q5;

  assign prod_p = PPW'(p2_q4) * PPW'(PDIV_MUL);

  always_ff @(posedge clk_i) begin
    s0_q1  <= s0;
    neg_q1 <= neg;
    p1_q   <= P1W'(mag) * P1W'(step_i);

    s0_q2  <= s0_q1;
    neg_q2 <= neg_q1;
    q1_q   <= prod_s[KS +: ANGLE_W];

    ang_q3 <= neg_q2 ? s0_q2 - q1_q : s0_q2 + q1_q;

    ang_q4 <= ang_q3;
    p2_q4  <= P2_W'(ang_q3) * P2_W'(span_mag);

    ang_q5 <= ang_q4;
    q2_q5  <= prod_p[PDIV_SHIFT +: PULSE_W];
  end

  // Stage 6: offset by pulse_min, drive the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= tag_q[4].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    last_o     <= tag_q[4].last;
    done_res_o <= tag_q[4].done;
    if (tag_q[4].done) begin
      out_channel_o <= '0;
      out_angle_o   <= '0;
      pulse_o       <= '0;
    end else begin
      out_channel_o <= CHW'(ch_q[4]);
      out_angle_o   <= ang_q5;
      pulse_o       <= span_neg ? pulse_min_q - q2_q5 : pulse_min_q + q2_q5;
    end
  end

  always_comb begin
    stat_o.pipe_busy = tag_q[0].valid || tag_q[1].valid || tag_q[2].valid
                       || tag_q[3].valid || tag_q[4].valid;
    stat_o.step_wait = step_wait_q;
  end

endmodule
